/* design/gtu_pkg.sv */
package gtu_pkg;

    localparam int POSITION_FRACTION_BITS = 16;
    localparam int SHIFT = 2 * POSITION_FRACTION_BITS - 16;

    localparam int PW    = 24;
    localparam int DW    = PW + 1;
    localparam int SW    = 2 * DW;
    localparam int RMW   = SW + 2;
    localparam int LW    = DW + 1;
    localparam int NW    = 16;
    localparam int NCOMP = 3;
    localparam int NORMW = NW * NCOMP;
    localparam int DIR_FRAC = 14;
    localparam int DIRW  = NW - 1;
    localparam int DXW   = DW + DIR_FRAC;
    localparam int DRW   = LW + 1;
    localparam int PRW   = 2 * NW;
    localparam int DOTW  = PRW + 2;
    localparam int COS_SHIFT = 12;
    localparam int CW    = 19;
    localparam int NUMW  = 2 * CW;
    localparam int QW    = 32;
    localparam int XW    = NUMW + SHIFT;
    localparam int CMPW  = (XW > SW + QW) ? XW : SW + QW;
    localparam int RW    = SW + 1;
    localparam int MDW   = 23;

    localparam logic [MDW-1:0] MIN_DISTANCE_RESET = MDW'(7);
    localparam logic [CW-1:0]  COS_ONE = CW'(65536);
    localparam logic [DIRW-1:0] DIR_ONE = DIRW'(16384);

    typedef logic signed [DW-1:0] diff_t;

    typedef struct packed {
        logic signed [PW-1:0] first_x;
        logic signed [PW-1:0] first_y;
        logic signed [PW-1:0] first_z;
        logic signed [PW-1:0] second_x;
        logic signed [PW-1:0] second_y;
        logic signed [PW-1:0] second_z;
        logic [NORMW-1:0]     first_normal;
        logic [NORMW-1:0]     second_normal;
        logic                 first_degenerate;
        logic                 second_degenerate;
    } pair_t;

    typedef struct packed {
        diff_t            dx;
        diff_t            dy;
        diff_t            dz;
        logic [NORMW-1:0] n1;
        logic [NORMW-1:0] n2;
        logic             deg1;
        logic             deg2;
    } geo_t;

    typedef struct packed {
        geo_t          g;
        logic [SW-1:0] sq;
    } sq_t;

    typedef struct packed {
        geo_t          g;
        logic [SW-1:0] sq;
        logic [LW-1:0] root;
    } root_t;

    typedef struct packed {
        logic [NORMW-1:0]     n1;
        logic [NORMW-1:0]     n2;
        logic                 deg1;
        logic                 deg2;
        logic [SW-1:0]        sq;
        logic                 kill;
        logic signed [NW-1:0] dir_x;
        logic signed [NW-1:0] dir_y;
        logic signed [NW-1:0] dir_z;
    } dir_t;

    typedef struct packed {
        logic [SW-1:0]   sq;
        logic            kill;
        logic [NUMW-1:0] num;
    } num_t;

    typedef struct packed {
        logic [QW-1:0] term;
        logic          sat;
    } term_t;

endpackage

/* design/gtu_pair_if.sv */
interface gtu_pair_if import gtu_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] first_x;
    logic signed [PW-1:0] first_y;
    logic signed [PW-1:0] first_z;
    logic signed [PW-1:0] second_x;
    logic signed [PW-1:0] second_y;
    logic signed [PW-1:0] second_z;
    logic [NORMW-1:0]     first_normal;
    logic [NORMW-1:0]     second_normal;
    logic                 first_degenerate;
    logic                 second_degenerate;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               first_normal, second_normal, first_degenerate, second_degenerate,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               first_normal, second_normal, first_degenerate, second_degenerate,
        output ready
    );
endinterface

/* design/gtu_term_if.sv */
interface gtu_term_if import gtu_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [QW-1:0] geometry_term;
    logic          saturated;

    modport source (output valid, geometry_term, saturated, input ready);
    modport sink (input valid, geometry_term, saturated, output ready);
endinterface

/* design/gtu_cfg_if.sv */
interface gtu_cfg_if import gtu_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [MDW-1:0] min_distance;

    modport source (output valid, min_distance, input ready);
    modport sink (input valid, min_distance, output ready);
endinterface

/* design/geometry_term_unit_top.sv */
// Throughput: one pair word per cycle while the output is not stalled; 3 setup, 26
// root, 16 direction, 3 cosine and 33 quotient stages, all moving on one shared
// advance enable.
// A stalled output holds every stage; the input is taken whenever the output
// word is taken or absent.
// Reset: pipeline valid bits clear, min_distance returns to 7.
module geometry_term_unit_top import gtu_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    gtu_pair_if.sink   pairs,
    gtu_term_if.source terms,
    gtu_cfg_if.sink    cfg
);

    logic [MDW-1:0] min_distance_reg;
    logic  en;
    pair_t pair_word;
    logic  sq_v, root_v, dir_v, num_v, out_v;
    sq_t   sq_word;
    root_t root_word;
    dir_t  dir_word;
    num_t  num_word;
    term_t out_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg <= MIN_DISTANCE_RESET;
        end
        else if (cfg.valid)
        begin
            min_distance_reg <= cfg.min_distance;
        end
    end

    assign cfg.ready   = 1'b1;
    assign en          = !out_v || terms.ready;
    assign pairs.ready = en;

    assign pair_word.first_x           = pairs.first_x;
    assign pair_word.first_y           = pairs.first_y;
    assign pair_word.first_z           = pairs.first_z;
    assign pair_word.second_x          = pairs.second_x;
    assign pair_word.second_y          = pairs.second_y;
    assign pair_word.second_z          = pairs.second_z;
    assign pair_word.first_normal      = pairs.first_normal;
    assign pair_word.second_normal     = pairs.second_normal;
    assign pair_word.first_degenerate  = pairs.first_degenerate;
    assign pair_word.second_degenerate = pairs.second_degenerate;

    gtu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pairs.valid),
        .in_word   (pair_word),
        .out_valid (sq_v),
        .out_word  (sq_word)
    );

    gtu_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_v),
        .in_word   (sq_word),
        .out_valid (root_v),
        .out_word  (root_word)
    );

    gtu_dirdiv u_dirdiv (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .min_distance (min_distance_reg),
        .in_valid     (root_v),
        .in_word      (root_word),
        .out_valid    (dir_v),
        .out_word     (dir_word)
    );

    gtu_cosine u_cosine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dir_v),
        .in_word   (dir_word),
        .out_valid (num_v),
        .out_word  (num_word)
    );

    gtu_qdiv u_qdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (num_v),
        .in_word   (num_word),
        .out_valid (out_v),
        .out_word  (out_word)
    );

    assign terms.valid         = out_v;
    assign terms.geometry_term = out_word.term;
    assign terms.saturated     = out_word.sat;

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (terms.valid && terms.saturated) |-> (&terms.geometry_term))
        else $error("saturated word without maximum term");

endmodule

/* design/gtu_front.sv */
module gtu_front import gtu_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  pair_t in_word,
    output logic  out_valid,
    output sq_t   out_word
);

    logic          v1_reg, v2_reg, v3_reg;
    geo_t          g1_reg, g2_reg, g3_reg;
    logic [SW-1:0] px_reg, py_reg, pz_reg, sq_reg;
    geo_t          g1_next;
    logic signed [SW-1:0] px_next, py_next, pz_next;

    always_comb
    begin
        g1_next.dx   = diff_t'(in_word.second_x) - diff_t'(in_word.first_x);
        g1_next.dy   = diff_t'(in_word.second_y) - diff_t'(in_word.first_y);
        g1_next.dz   = diff_t'(in_word.second_z) - diff_t'(in_word.first_z);
        g1_next.n1   = in_word.first_normal;
        g1_next.n2   = in_word.second_normal;
        g1_next.deg1 = in_word.first_degenerate;
        g1_next.deg2 = in_word.second_degenerate;
        px_next      = g1_reg.dx * g1_reg.dx;
        py_next      = g1_reg.dy * g1_reg.dy;
        pz_next      = g1_reg.dz * g1_reg.dz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_reg <= g1_next;
            g2_reg <= g1_reg;
            px_reg <= $unsigned(px_next);
            py_reg <= $unsigned(py_next);
            pz_reg <= $unsigned(pz_next);
            g3_reg <= g2_reg;
            sq_reg <= px_reg + py_reg + pz_reg;
        end
    end

    assign out_valid   = v3_reg;
    assign out_word.g  = g3_reg;
    assign out_word.sq = sq_reg;

endmodule

/* design/gtu_isqrt.sv */
module gtu_isqrt import gtu_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  sq_t   in_word,
    output logic  out_valid,
    output root_t out_word
);

    typedef struct packed {
        geo_t          g;
        logic [SW-1:0] sq;
        logic [SW-1:0] rem;
        logic [LW-1:0] root;
    } sqrt_stage_t;

    logic        v_reg  [LW];
    sqrt_stage_t st_reg [LW];

    for (genvar s = 0; s < LW; s++)
    begin : g_stage
        localparam int B = LW - 1 - s;
        sqrt_stage_t   cur;
        logic          cur_v;
        sqrt_stage_t   stage_next;
        logic [RMW-1:0] trial;

        if (s == 0)
        begin : g_first
            assign cur_v    = in_valid;
            assign cur.g    = in_word.g;
            assign cur.sq   = in_word.sq;
            assign cur.rem  = in_word.sq;
            assign cur.root = '0;
        end
        else
        begin : g_chain
            assign cur_v = v_reg[s-1];
            assign cur   = st_reg[s-1];
        end

        always_comb
        begin
            trial      = (RMW'(cur.root) << (B + 1)) + (RMW'(1) << (2 * B));
            stage_next = cur;
            if (RMW'(cur.rem) >= trial)
            begin
                stage_next.rem  = cur.rem - SW'(trial);
                stage_next.root = cur.root | (LW'(1) << B);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[s] <= stage_next;
            end
        end
    end

    assign out_valid     = v_reg[LW-1];
    assign out_word.g    = st_reg[LW-1].g;
    assign out_word.sq   = st_reg[LW-1].sq;
    assign out_word.root = st_reg[LW-1].root;

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (64'(out_word.root) * 64'(out_word.root) <= 64'(out_word.sq))
                   && ((64'(out_word.root) + 64'd1) * (64'(out_word.root) + 64'd1)
                       > 64'(out_word.sq)))
        else $error("square root stage result is not the floor root");

endmodule

/* design/gtu_dirdiv.sv */
module gtu_dirdiv import gtu_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [MDW-1:0] min_distance,
    input  logic           in_valid,
    input  root_t          in_word,
    output logic           out_valid,
    output dir_t           out_word
);

    localparam int NS = DIRW + 1;

    typedef struct packed {
        logic [NORMW-1:0] n1;
        logic [NORMW-1:0] n2;
        logic             deg1;
        logic             deg2;
        logic [SW-1:0]    sq;
        logic             kill;
        logic [LW-1:0]    div;
    } dcom_t;

    typedef struct packed {
        logic            neg;
        logic [DRW-1:0]  rem;
        logic [DIRW-1:0] low;
        logic [DIRW-1:0] q;
    } dlane_t;

    logic   v_reg    [NS];
    dcom_t  com_reg  [NS];
    dlane_t lane_reg [NS][NCOMP];

    dcom_t  com_next;
    dlane_t lane_next [NCOMP];
    diff_t  d_in      [NCOMP];

    assign d_in[0] = in_word.g.dx;
    assign d_in[1] = in_word.g.dy;
    assign d_in[2] = in_word.g.dz;

    always_comb
    begin
        logic [DW-1:0]  mag;
        logic [DXW-1:0] x;
        com_next.n1   = in_word.g.n1;
        com_next.n2   = in_word.g.n2;
        com_next.deg1 = in_word.g.deg1;
        com_next.deg2 = in_word.g.deg2;
        com_next.sq   = in_word.sq;
        com_next.kill = (in_word.sq == '0) || (in_word.root < LW'(min_distance));
        com_next.div  = in_word.root;
        for (int i = 0; i < NCOMP; i++)
        begin
            mag = d_in[i][DW-1] ? $unsigned(-d_in[i]) : $unsigned(d_in[i]);
            x   = (DXW'(mag) << DIR_FRAC) + DXW'(in_word.root >> 1);
            lane_next[i].neg = d_in[i][DW-1];
            lane_next[i].rem = DRW'(x >> DIRW);
            lane_next[i].low = x[DIRW-1:0];
            lane_next[i].q   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            com_reg[0] <= com_next;
            for (int i = 0; i < NCOMP; i++)
            begin
                lane_reg[0][i] <= lane_next[i];
            end
        end
    end

    for (genvar s = 1; s < NS; s++)
    begin : g_step
        localparam int B = DIRW - s;
        dlane_t step_next [NCOMP];

        always_comb
        begin
            logic [DRW-1:0] t;
            for (int i = 0; i < NCOMP; i++)
            begin
                t            = {lane_reg[s-1][i].rem[DRW-2:0], lane_reg[s-1][i].low[B]};
                step_next[i] = lane_reg[s-1][i];
                if (t >= DRW'(com_reg[s-1].div))
                begin
                    step_next[i].rem  = t - DRW'(com_reg[s-1].div);
                    step_next[i].q[B] = 1'b1;
                end
                else
                begin
                    step_next[i].rem = t;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                com_reg[s] <= com_reg[s-1];
                for (int i = 0; i < NCOMP; i++)
                begin
                    lane_reg[s][i] <= step_next[i];
                end
            end
        end
    end

    logic signed [NW-1:0] dir_out [NCOMP];

    for (genvar i = 0; i < NCOMP; i++)
    begin : g_sign
        assign dir_out[i] = lane_reg[NS-1][i].neg
                          ? -$signed(NW'(lane_reg[NS-1][i].q))
                          : $signed(NW'(lane_reg[NS-1][i].q));
    end

    assign out_valid     = v_reg[NS-1];
    assign out_word.n1   = com_reg[NS-1].n1;
    assign out_word.n2   = com_reg[NS-1].n2;
    assign out_word.deg1 = com_reg[NS-1].deg1;
    assign out_word.deg2 = com_reg[NS-1].deg2;
    assign out_word.sq   = com_reg[NS-1].sq;
    assign out_word.kill = com_reg[NS-1].kill;
    assign out_word.dir_x = dir_out[0];
    assign out_word.dir_y = dir_out[1];
    assign out_word.dir_z = dir_out[2];

    a_dir_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.kill) |->
            (lane_reg[NS-1][0].q <= DIR_ONE) && (lane_reg[NS-1][1].q <= DIR_ONE)
            && (lane_reg[NS-1][2].q <= DIR_ONE))
        else $error("direction component exceeds unit magnitude");

endmodule

/* design/gtu_cosine.sv */
module gtu_cosine import gtu_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  dir_t in_word,
    output logic out_valid,
    output num_t out_word
);

    typedef struct packed {
        logic [SW-1:0] sq;
        logic          kill;
        logic          deg1;
        logic          deg2;
    } ccom_t;

    logic                  v1_reg, v2_reg, v3_reg;
    ccom_t                 c1_reg, c2_reg;
    num_t                  n3_reg;
    logic signed [PRW-1:0] p_reg [2][NCOMP];
    logic [CW-1:0]         cos_reg [2];

    logic signed [PRW-1:0] p_next   [2][NCOMP];
    logic [CW-1:0]         cos_next [2];
    logic [NORMW-1:0]      nrm [2];
    logic signed [NW-1:0]  dir [NCOMP];
    ccom_t                 c1_next;

    assign nrm[0] = in_word.n1;
    assign nrm[1] = in_word.n2;
    assign dir[0] = in_word.dir_x;
    assign dir[1] = in_word.dir_y;
    assign dir[2] = in_word.dir_z;

    always_comb
    begin
        c1_next.sq   = in_word.sq;
        c1_next.kill = in_word.kill;
        c1_next.deg1 = in_word.deg1;
        c1_next.deg2 = in_word.deg2;
        for (int e = 0; e < 2; e++)
        begin
            for (int i = 0; i < NCOMP; i++)
            begin
                p_next[e][i] = $signed(nrm[e][NW*i +: NW]) * dir[i];
            end
        end
    end

    always_comb
    begin
        logic signed [DOTW-1:0] dot;
        logic [DOTW-1:0]        mag;
        logic                   deg;
        for (int e = 0; e < 2; e++)
        begin
            dot = DOTW'(p_reg[e][0]) + DOTW'(p_reg[e][1]) + DOTW'(p_reg[e][2]);
            mag = dot[DOTW-1] ? $unsigned(-dot) : $unsigned(dot);
            deg = (e == 0) ? c1_reg.deg1 : c1_reg.deg2;
            cos_next[e] = deg ? COS_ONE : CW'(mag >> COS_SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg      <= c1_next;
            p_reg       <= p_next;
            c2_reg      <= c1_reg;
            cos_reg     <= cos_next;
            n3_reg.sq   <= c2_reg.sq;
            n3_reg.kill <= c2_reg.kill;
            n3_reg.num  <= NUMW'(cos_reg[0]) * NUMW'(cos_reg[1]);
        end
    end

    assign out_valid = v3_reg;
    assign out_word  = n3_reg;

endmodule

/* design/gtu_qdiv.sv */
module gtu_qdiv import gtu_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  num_t  in_word,
    output logic  out_valid,
    output term_t out_word
);

    localparam int NS = QW + 1;

    typedef struct packed {
        logic          kill;
        logic          ovf;
        logic [SW-1:0] sq;
        logic [RW-1:0] rem;
        logic [QW-1:0] low;
        logic [QW-1:0] q;
    } qstage_t;

    logic    v_reg  [NS];
    qstage_t st_reg [NS];
    qstage_t first_next;

    always_comb
    begin
        logic [XW-1:0]   x;
        logic [CMPW-1:0] a;
        logic [CMPW-1:0] b;
        x = XW'(in_word.num) << SHIFT;
        a = CMPW'(in_word.num) << SHIFT;
        b = CMPW'(in_word.sq) << QW;
        first_next.kill = in_word.kill;
        first_next.ovf  = (a >= b);
        first_next.sq   = in_word.sq;
        first_next.rem  = RW'(x >> QW);
        first_next.low  = x[QW-1:0];
        first_next.q    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= first_next;
        end
    end

    for (genvar s = 1; s < NS; s++)
    begin : g_step
        localparam int B = QW - s;
        qstage_t step_next;

        always_comb
        begin
            logic [RW-1:0] t;
            t         = {st_reg[s-1].rem[RW-2:0], st_reg[s-1].low[B]};
            step_next = st_reg[s-1];
            if (t >= RW'(st_reg[s-1].sq))
            begin
                step_next.rem  = t - RW'(st_reg[s-1].sq);
                step_next.q[B] = 1'b1;
            end
            else
            begin
                step_next.rem = t;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[s] <= step_next;
            end
        end
    end

    assign out_valid     = v_reg[NS-1];
    assign out_word.term = st_reg[NS-1].kill ? '0
                         : (st_reg[NS-1].ovf ? '1 : st_reg[NS-1].q);
    assign out_word.sat  = !st_reg[NS-1].kill && st_reg[NS-1].ovf;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !st_reg[NS-1].kill && !st_reg[NS-1].ovf) |->
            (st_reg[NS-1].rem < RW'(st_reg[NS-1].sq)))
        else $error("divider remainder not below divisor");

endmodule

/* tb/sv/geometry_term_unit_top_test.sv */
module geometry_term_unit_top_test;
    import gtu_pkg::*;

    typedef struct {
        logic [QW-1:0] term;
        logic          sat;
    } term_exp_t;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   error_count;
    int   gap_left;
    int   burst_left;
    logic [MDW-1:0] min_dist;
    term_exp_t term_queue[$];

    gtu_pair_if pairs ();
    gtu_term_if terms ();
    gtu_cfg_if  cfg ();

    geometry_term_unit_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pairs (pairs),
        .terms (terms),
        .cfg   (cfg)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("geometry_term_unit_top_test: errors");
            $finish;
        end
    end

    function automatic longint unsigned floor_root(longint unsigned s);
        longint unsigned root;
        longint unsigned bit_v;
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > s)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (s >= root + bit_v)
            begin
                s -= root + bit_v;
                root = (root >> 1) + bit_v;
            end
            else
                root >>= 1;
            bit_v >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned cos_of(logic [NORMW-1:0] n, longint dir[3]);
        longint dot;
        dot = 0;
        for (int i = 0; i < NCOMP; i++)
            dot += longint'($signed(n[NW*i +: NW])) * dir[i];
        if (dot < 0)
            dot = -dot;
        return longint'(dot) >> COS_SHIFT;
    endfunction

    function automatic term_exp_t predict_term(pair_t p);
        term_exp_t e;
        longint diff[3];
        longint dir[3];
        longint unsigned sq, len, mag, c1, c2, num, q, r;
        e.term = '0;
        e.sat = 1'b0;
        diff[0] = longint'(p.second_x) - longint'(p.first_x);
        diff[1] = longint'(p.second_y) - longint'(p.first_y);
        diff[2] = longint'(p.second_z) - longint'(p.first_z);
        sq = 0;
        for (int i = 0; i < 3; i++)
            sq += diff[i] * diff[i];
        len = floor_root(sq);
        if (sq == 0 || len < min_dist)
            return e;
        for (int i = 0; i < 3; i++)
        begin
            mag = diff[i] < 0 ? -diff[i] : diff[i];
            dir[i] = (mag * 16384 + len / 2) / len;
            if (diff[i] < 0)
                dir[i] = -dir[i];
        end
        c1 = p.first_degenerate ? 65536 : cos_of(p.first_normal, dir);
        c2 = p.second_degenerate ? 65536 : cos_of(p.second_normal, dir);
        num = c1 * c2;
        q = num / sq;
        r = num % sq;
        if (q > 64'hFFFF_FFFF)
        begin
            e.term = '1;
            e.sat = 1'b1;
            return e;
        end
        for (int i = 0; i < SHIFT; i++)
        begin
            r <<= 1;
            q <<= 1;
            if (r >= sq)
            begin
                r -= sq;
                q |= 1;
            end
            if (q > 64'hFFFF_FFFF)
            begin
                e.term = '1;
                e.sat = 1'b1;
                return e;
            end
        end
        e.term = q[31:0];
        return e;
    endfunction

    // check each term word; the block after this one drives the output stall pattern
    always @(posedge clk)
    begin
        term_exp_t e;
        if (rst_n && terms.valid && terms.ready)
        begin
            if (term_queue.size() == 0)
            begin
                $display("%0t: unexpected term word %h sat %b", $time,
                         terms.geometry_term, terms.saturated);
                error_count++;
            end
            else
            begin
                e = term_queue.pop_front();
                if (e.term !== terms.geometry_term)
                begin
                    $display("%0t: geometry_term expected %h actual %h", $time,
                             e.term, terms.geometry_term);
                    error_count++;
                end
                if (e.sat !== terms.saturated)
                begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             e.sat, terms.saturated);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (cycle_count % 2000 < 700)
            terms.ready <= 1'b1;
        else
            terms.ready <= ($urandom_range(0, 3) != 0) && (cycle_count % 37 > 4);
    end

    task automatic send_pair(pair_t p);
        if (burst_left == 0)
        begin
            gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
            burst_left = $urandom_range(1, 20);
        end
        while (gap_left > 0)
        begin
            pairs.valid <= 1'b0;
            @(negedge clk);
            gap_left--;
        end
        burst_left--;
        pairs.valid <= 1'b1;
        pairs.first_x <= p.first_x;
        pairs.first_y <= p.first_y;
        pairs.first_z <= p.first_z;
        pairs.second_x <= p.second_x;
        pairs.second_y <= p.second_y;
        pairs.second_z <= p.second_z;
        pairs.first_normal <= p.first_normal;
        pairs.second_normal <= p.second_normal;
        pairs.first_degenerate <= p.first_degenerate;
        pairs.second_degenerate <= p.second_degenerate;
        do
            @(posedge clk);
        while (!pairs.ready);
        term_queue.push_back(predict_term(p));
        @(negedge clk);
    endtask

    task automatic drain_terms();
        pairs.valid <= 1'b0;
        while (term_queue.size() != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
    endtask

    task automatic write_min_distance(logic [MDW-1:0] v);
        drain_terms();
        cfg.valid <= 1'b1;
        cfg.min_distance <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        min_dist = v;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [NORMW-1:0] unit_normal(int axis, bit neg);
        logic [NORMW-1:0] n;
        n = '0;
        n[NW*axis +: NW] = neg ? -16'sd16384 : 16'sd16384;
        return n;
    endfunction

    function automatic pair_t random_pair(int span);
        pair_t p;
        logic signed [PW-1:0] base;
        int mode;
        mode = $urandom_range(0, 9);
        p.first_x = PW'($urandom);
        p.first_y = PW'($urandom);
        p.first_z = PW'($urandom);
        if (mode < 6)
        begin
            p.second_x = p.first_x + PW'($signed($urandom_range(0, 2 * span) - span));
            p.second_y = p.first_y + PW'($signed($urandom_range(0, 2 * span) - span));
            p.second_z = p.first_z + PW'($signed($urandom_range(0, 2 * span) - span));
        end
        else
        begin
            p.second_x = PW'($urandom);
            p.second_y = PW'($urandom);
            p.second_z = PW'($urandom);
        end
        if (mode == 9)
        begin
            base = PW'($urandom);
            p.first_x = base;
            p.second_x = base + PW'(1);
            p.second_y = p.first_y;
            p.second_z = p.first_z;
        end
        if ($urandom_range(0, 1))
        begin
            p.first_normal = NORMW'({$urandom, $urandom});
            p.second_normal = NORMW'({$urandom, $urandom});
        end
        else
        begin
            p.first_normal = unit_normal(int'($urandom_range(0, 2)),
                                         1'($urandom_range(0, 1)));
            p.second_normal = unit_normal(int'($urandom_range(0, 2)),
                                          1'($urandom_range(0, 1)));
        end
        p.first_degenerate = $urandom_range(0, 3) == 0;
        p.second_degenerate = $urandom_range(0, 3) == 0;
        return p;
    endfunction

    function automatic pair_t axis_pair(int offset, bit d1, bit d2);
        pair_t p;
        p = '0;
        p.second_x = PW'(offset);
        p.first_normal = unit_normal(0, 0);
        p.second_normal = unit_normal(0, 1);
        p.first_degenerate = d1;
        p.second_degenerate = d2;
        return p;
    endfunction

    task automatic test_directed();
        pair_t p;
        send_pair(axis_pair(0, 0, 0));
        send_pair(axis_pair(6, 0, 0));
        send_pair(axis_pair(7, 0, 0));
        send_pair(axis_pair(65536, 0, 0));
        send_pair(axis_pair(65536, 1, 1));
        send_pair(axis_pair(-65536, 1, 0));
        send_pair(axis_pair(300, 0, 1));
        p = axis_pair(65536, 0, 0);
        p.first_normal = unit_normal(1, 0);
        send_pair(p);
        p = '0;
        p.first_x = 24'sh800000;
        p.first_y = 24'sh800000;
        p.first_z = 24'sh800000;
        p.second_x = 24'sh7FFFFF;
        p.second_y = 24'sh7FFFFF;
        p.second_z = 24'sh7FFFFF;
        p.first_normal = '1;
        p.second_normal = {3{16'h8000}};
        send_pair(p);
        p.first_degenerate = 1'b1;
        p.second_degenerate = 1'b1;
        send_pair(p);
        p.first_normal = {3{16'h7FFF}};
        p.second_normal = {3{16'h7FFF}};
        p.first_degenerate = 1'b0;
        p.second_degenerate = 1'b0;
        send_pair(p);
        p = '0;
        p.first_x = 24'sh7FFFFF;
        p.second_y = 24'sh800000;
        p.first_normal = NORMW'({$urandom, $urandom});
        p.second_normal = NORMW'({$urandom, $urandom});
        send_pair(p);
    endtask

    task automatic test_threshold_sweep();
        write_min_distance('0);
        send_pair(axis_pair(0, 0, 0));
        send_pair(axis_pair(1, 1, 1));
        send_pair(axis_pair(1, 0, 0));
        for (int i = 0; i < 100; i++)
            send_pair(random_pair(64));
        write_min_distance(23'h7FFFFF);
        for (int i = 0; i < 60; i++)
            send_pair(random_pair(1 << 23));
        write_min_distance(23'd65536);
        for (int i = 0; i < 200; i++)
            send_pair(random_pair(1 << 18));
    endtask

    task automatic test_random_pairs();
        int span;
        write_min_distance(MIN_DISTANCE_RESET);
        for (int i = 0; i < 900; i++)
        begin
            case ($urandom_range(0, 3))
                0: span = 32;
                1: span = 4096;
                2: span = 1 << 17;
                default: span = 1 << 22;
            endcase
            send_pair(random_pair(span));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycle_count = 0;
        error_count = 0;
        gap_left = 0;
        burst_left = 0;
        min_dist = MIN_DISTANCE_RESET;
        pairs.valid = 1'b0;
        pairs.first_x = '0;
        pairs.first_y = '0;
        pairs.first_z = '0;
        pairs.second_x = '0;
        pairs.second_y = '0;
        pairs.second_z = '0;
        pairs.first_normal = '0;
        pairs.second_normal = '0;
        pairs.first_degenerate = 1'b0;
        pairs.second_degenerate = 1'b0;
        terms.ready = 1'b1;
        cfg.valid = 1'b0;
        cfg.min_distance = '0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_threshold_sweep();
        test_random_pairs();
        drain_terms();
        if (error_count == 0)
            $display("geometry_term_unit_top_test: clean");
        else
            $display("geometry_term_unit_top_test: errors");
        $finish;
    end

endmodule
